[rtl/funnel_path_smoother_top_macros.svh]
// Assertion macros for the funnel path smoother checker
`ifndef FUNNEL_PATH_SMOOTHER_TOP_MACROS_SVH
`define FUNNEL_PATH_SMOOTHER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define FPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define FPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fps_pkg.sv]
// Shared types and constants for the funnel path smoother
package fps_pkg;

    localparam int COORD_W  = 32;
    localparam int RADIUS_W = 31;
    localparam int FUNC_W   = 2;

    localparam logic [FUNC_W-1:0] FUNC_START  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_PORTAL = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_DEST   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } point_t;

    typedef struct packed {
        point_t l_pt;
        point_t r_pt;
    } edge_t;

endpackage

[rtl/fps_shrink.sv]
// Portal edge shrink unit: bit-serial length root and offset divisions
module fps_shrink (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  fps_pkg::point_t                 a_pt,
    input  fps_pkg::point_t                 b_pt,
    input  logic [fps_pkg::RADIUS_W-1:0]    radius,
    output logic                            done,
    output fps_pkg::edge_t                  result
);
    import fps_pkg::*;

    typedef enum logic [3:0] {
        SH_IDLE, SH_MAG, SH_SQ, SH_ACC, SH_ROOT, SH_MUL, SH_DIVI, SH_DIV, SH_OUT
    } sh_state_t;

    sh_state_t                 state_reg;
    point_t                    a_reg;
    point_t                    b_reg;
    logic signed [COORD_W:0]   d_reg [3];
    logic [COORD_W-1:0]        q_reg [3];
    logic [RADIUS_W-1:0]       off_reg [3];
    logic [1:0]                k_reg;
    logic [63:0]               prod_reg;
    logic [63:0]               sum_reg;
    logic [63:0]               root_v_reg;
    logic [63:0]               root_res_reg;
    logic [63:0]               root_bit_reg;
    logic [4:0]                root_step_reg;
    logic [COORD_W-1:0]        len_reg;
    logic [63:0]               num_reg;
    logic [COORD_W:0]          rem_reg;
    logic [COORD_W-1:0]        quot_reg;
    logic [5:0]                div_step_reg;
    logic                      done_reg;
    edge_t                     result_reg;

    logic [COORD_W:0]          mag_d [3];
    logic                      big;
    logic [63:0]               root_t;
    logic                      root_ge;
    logic [63:0]               root_res_next;
    logic [COORD_W:0]          rem_shift;
    logic                      rem_ge;
    logic [COORD_W-1:0]        quot_next;
    point_t                    l_calc;
    point_t                    r_calc;

    function automatic logic signed [COORD_W-1:0] sat32(input logic signed [COORD_W:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[COORD_W] != v[COORD_W-1]) begin
            r = v[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [COORD_W:0] signed_off(
        input logic signed [COORD_W:0] d, input logic [RADIUS_W-1:0] o);
        logic signed [COORD_W:0] s;
        s = $signed({2'b00, o});
        return d[COORD_W] ? -s : s;
    endfunction

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            mag_d[k] = d_reg[k][COORD_W] ? COORD_W'(0) - d_reg[k] : d_reg[k];
        end
        big = (|mag_d[0][COORD_W:COORD_W-1]) | (|mag_d[1][COORD_W:COORD_W-1])
            | (|mag_d[2][COORD_W:COORD_W-1]);

        root_t        = root_res_reg + root_bit_reg;
        root_ge       = root_v_reg >= root_t;
        root_res_next = root_ge ? (root_res_reg >> 1) + root_bit_reg : root_res_reg >> 1;

        rem_shift = {rem_reg[COORD_W-1:0], num_reg[63]};
        rem_ge    = rem_shift >= {1'b0, len_reg};
        quot_next = {quot_reg[COORD_W-2:0], rem_ge};

        l_calc.x = sat32(33'(b_reg.x) + signed_off(d_reg[0], off_reg[0]));
        l_calc.y = sat32(33'(b_reg.y) + signed_off(d_reg[1], off_reg[1]));
        l_calc.z = sat32(33'(b_reg.z) + signed_off(d_reg[2], off_reg[2]));
        r_calc.x = sat32(33'(a_reg.x) - signed_off(d_reg[0], off_reg[0]));
        r_calc.y = sat32(33'(a_reg.y) - signed_off(d_reg[1], off_reg[1]));
        r_calc.z = sat32(33'(a_reg.z) - signed_off(d_reg[2], off_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SH_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == SH_OUT);
            unique case (state_reg)
                SH_IDLE:
                begin
                    if (start)
                    begin
                        a_reg    <= a_pt;
                        b_reg    <= b_pt;
                        d_reg[0] <= 33'(a_pt.x) - 33'(b_pt.x);
                        d_reg[1] <= 33'(a_pt.y) - 33'(b_pt.y);
                        d_reg[2] <= 33'(a_pt.z) - 33'(b_pt.z);
                        state_reg <= SH_MAG;
                    end
                end
                SH_MAG:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        q_reg[k] <= big ? mag_d[k][COORD_W:1] : mag_d[k][COORD_W-1:0];
                    end
                    k_reg     <= 2'd0;
                    sum_reg   <= '0;
                    state_reg <= SH_SQ;
                end
                SH_SQ:
                begin
                    prod_reg  <= q_reg[k_reg] * q_reg[k_reg];
                    state_reg <= SH_ACC;
                end
                SH_ACC:
                begin
                    sum_reg <= sum_reg + prod_reg;
                    if (k_reg == 2'd2)
                    begin
                        root_v_reg    <= sum_reg + prod_reg;
                        root_res_reg  <= '0;
                        root_bit_reg  <= 64'd1 << 62;
                        root_step_reg <= '0;
                        state_reg     <= SH_ROOT;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= SH_SQ;
                    end
                end
                SH_ROOT:
                begin
                    if (root_ge)
                    begin
                        root_v_reg <= root_v_reg - root_t;
                    end
                    root_res_reg  <= root_res_next;
                    root_bit_reg  <= root_bit_reg >> 2;
                    root_step_reg <= root_step_reg + 5'd1;
                    if (root_step_reg == 5'd31)
                    begin
                        len_reg   <= root_res_next[COORD_W-1:0];
                        k_reg     <= 2'd0;
                        state_reg <= SH_MUL;
                    end
                end
                SH_MUL:
                begin
                    prod_reg  <= 64'(q_reg[k_reg]) * 64'(radius);
                    state_reg <= SH_DIVI;
                end
                SH_DIVI:
                begin
                    num_reg      <= prod_reg + 64'(len_reg >> 1);
                    rem_reg      <= '0;
                    quot_reg     <= '0;
                    div_step_reg <= '0;
                    if (len_reg == '0)
                    begin
                        off_reg[k_reg] <= '0;
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd2) ? SH_OUT : SH_MUL;
                    end
                    else
                    begin
                        state_reg <= SH_DIV;
                    end
                end
                SH_DIV:
                begin
                    rem_reg      <= rem_ge ? rem_shift - {1'b0, len_reg} : rem_shift;
                    quot_reg     <= quot_next;
                    num_reg      <= num_reg << 1;
                    div_step_reg <= div_step_reg + 6'd1;
                    if (div_step_reg == 6'd63)
                    begin
                        off_reg[k_reg] <= quot_next[RADIUS_W-1:0];
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= (k_reg == 2'd2) ? SH_OUT : SH_MUL;
                    end
                end
                SH_OUT:
                begin
                    result_reg.l_pt <= l_calc;
                    result_reg.r_pt <= r_calc;
                    state_reg       <= SH_IDLE;
                end
                default:
                begin
                    state_reg <= SH_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[rtl/funnel_path_smoother_top.sv]
// Funnel path smoother top level: portal store and string-pulling funnel scan
// Items are taken one at a time; in_stall stays high while one is in work. A portal item
// is worked by the shrink unit unless the store is full: three squares, a 32-step
// bit-serial square root and three 64-step restoring divisions. A destination item runs
// the setup states S_INIT and S_INIT2, then for every visited portal one read of the
// portal memory and up to four area signs through one shared pair of multipliers, plus
// a wait on out_stall for every waypoint; a restart revisits portals from the new apex.
// Results leave through one output register, so the next result is worked on while the
// previous one waits. No memory clearing pass follows reset.
module funnel_path_smoother_top #(
    parameter int MAX_PORTALS = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [fps_pkg::FUNC_W-1:0]          func,
    input  logic signed [fps_pkg::COORD_W-1:0]  ax,
    input  logic signed [fps_pkg::COORD_W-1:0]  ay,
    input  logic signed [fps_pkg::COORD_W-1:0]  az,
    input  logic signed [fps_pkg::COORD_W-1:0]  bx,
    input  logic signed [fps_pkg::COORD_W-1:0]  by,
    input  logic signed [fps_pkg::COORD_W-1:0]  bz,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [fps_pkg::COORD_W-1:0]  wx,
    output logic signed [fps_pkg::COORD_W-1:0]  wy,
    output logic signed [fps_pkg::COORD_W-1:0]  wz,
    output logic                                last,
    output logic                                overflowed,
    input  logic                                shrink_radius_we,
    input  logic [fps_pkg::RADIUS_W-1:0]        shrink_radius_wdata
);
    import fps_pkg::*;

    localparam int DEPTH  = MAX_PORTALS + 2;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(MAX_PORTALS + 3);
    localparam logic [63:0] EQ_TOL = ((64'd1 << (2 * FRAC_BITS)) / 64'd1000000) + 64'd1;

    typedef enum logic [4:0] {
        S_IDLE, S_SHRINK, S_INIT, S_INIT2, S_CHECK, S_RD, S_LD,
        S_M1, S_C1, S_M2, S_C2, S_M3, S_C3, S_M4, S_C4, S_EMIT, S_DEST
    } state_t;

    state_t                     state_reg;
    logic [RADIUS_W-1:0]        radius_reg;
    logic [CNT_W-1:0]           count_reg;
    logic                       dropped_reg;
    logic [CNT_W-1:0]           endi_reg;
    logic [CNT_W-1:0]           i_reg;
    logic [CNT_W-1:0]           n_reg;
    logic [CNT_W-1:0]           lidx_reg;
    logic [CNT_W-1:0]           ridx_reg;
    point_t                     apex_reg;
    point_t                     left_reg;
    point_t                     right_reg;
    point_t                     nl_reg;
    point_t                     nr_reg;
    point_t                     dest_reg;
    point_t                     emit_reg;
    logic                       near_pl_reg;
    logic                       near_pr_reg;
    logic signed [65:0]         p1_reg;
    logic signed [65:0]         p2_reg;
    logic                       out_valid_reg;
    point_t                     out_pt_reg;
    logic                       out_last_reg;
    logic                       out_ovf_reg;

    point_t                     left_mem [DEPTH];
    point_t                     right_mem [DEPTH];
    point_t                     rd_l_reg;
    point_t                     rd_r_reg;

    point_t                     a_in;
    point_t                     b_in;
    logic                       accept;
    logic                       shrink_start;
    logic                       shrink_done;
    edge_t                      shrink_edge;
    logic                       wr_en;
    logic [ADDR_W-1:0]          wr_addr;
    point_t                     wr_l;
    point_t                     wr_r;
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    point_t                     tri_b;
    point_t                     tri_c;
    logic signed [COORD_W:0]    dbx;
    logic signed [COORD_W:0]    dby;
    logic signed [COORD_W:0]    dcx;
    logic signed [COORD_W:0]    dcy;
    logic signed [66:0]         tri_diff;
    logic                       tri_pos;
    logic                       tri_neg;
    logic                       slot_free;
    logic                       out_load;
    logic [CNT_W-1:0]           count_inc;

    function automatic logic near_eq(input point_t p, input point_t q);
        logic signed [COORD_W:0] dx;
        logic signed [COORD_W:0] dy;
        logic [COORD_W:0]        mx;
        logic [COORD_W:0]        my;
        logic [31:0]             sx;
        logic [31:0]             sy;
        logic [32:0]             s;
        dx = 33'(p.x) - 33'(q.x);
        dy = 33'(p.y) - 33'(q.y);
        mx = dx[COORD_W] ? COORD_W'(0) - dx : dx;
        my = dy[COORD_W] ? COORD_W'(0) - dy : dy;
        sx = mx[15:0] * mx[15:0];
        sy = my[15:0] * my[15:0];
        s  = 33'(sx) + 33'(sy);
        return !(|mx[COORD_W:16]) && !(|my[COORD_W:16]) && (64'(s) < EQ_TOL);
    endfunction

    fps_shrink u_shrink (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (shrink_start),
        .a_pt   (a_in),
        .b_pt   (b_in),
        .radius (radius_reg),
        .done   (shrink_done),
        .result (shrink_edge)
    );

    assign a_in.x    = ax;
    assign a_in.y    = ay;
    assign a_in.z    = az;
    assign b_in.x    = bx;
    assign b_in.y    = by;
    assign b_in.z    = bz;
    assign accept    = in_valid && (state_reg == S_IDLE);
    assign in_stall  = (state_reg != S_IDLE);
    assign count_inc = count_reg + CNT_W'(1);
    assign shrink_start = accept && (func == FUNC_PORTAL)
                          && (count_reg < CNT_W'(MAX_PORTALS));
    assign slot_free = !out_valid_reg || !out_stall;
    assign out_load  = slot_free && ((state_reg == S_EMIT) || (state_reg == S_DEST));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_inc[ADDR_W-1:0];
        wr_l    = a_in;
        wr_r    = a_in;
        if (accept && (func == FUNC_START))
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
        end
        else if (accept && (func == FUNC_DEST))
        begin
            wr_en = 1'b1;
        end
        else if ((state_reg == S_SHRINK) && shrink_done)
        begin
            wr_en = 1'b1;
            wr_l  = shrink_edge.l_pt;
            wr_r  = shrink_edge.r_pt;
        end
    end

    assign rd_en   = (state_reg == S_INIT) || (state_reg == S_RD);
    assign rd_addr = (state_reg == S_INIT) ? '0 : i_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= wr_l;
            right_mem[wr_addr] <= wr_r;
        end
        if (rd_en)
        begin
            rd_l_reg <= left_mem[rd_addr];
            rd_r_reg <= right_mem[rd_addr];
        end
    end

    always_comb
    begin
        tri_b = right_reg;
        tri_c = nr_reg;
        case (state_reg)
            S_M2:
            begin
                tri_b = left_reg;
                tri_c = nr_reg;
            end
            S_M3:
            begin
                tri_b = left_reg;
                tri_c = nl_reg;
            end
            S_M4:
            begin
                tri_b = right_reg;
                tri_c = nl_reg;
            end
            default:
            begin
                tri_b = right_reg;
                tri_c = nr_reg;
            end
        endcase
        dbx      = 33'(tri_b.x) - 33'(apex_reg.x);
        dby      = 33'(tri_b.y) - 33'(apex_reg.y);
        dcx      = 33'(tri_c.x) - 33'(apex_reg.x);
        dcy      = 33'(tri_c.y) - 33'(apex_reg.y);
        tri_diff = 67'(p1_reg) - 67'(p2_reg);
        tri_neg  = tri_diff[66];
        tri_pos  = !tri_diff[66] && (tri_diff != '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            radius_reg    <= '0;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (shrink_radius_we)
            begin
                radius_reg <= shrink_radius_wdata;
            end
            if (out_valid_reg && !out_stall && !out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (func)
                            FUNC_START:
                            begin
                                count_reg   <= '0;
                                dropped_reg <= 1'b0;
                            end
                            FUNC_PORTAL:
                            begin
                                if (shrink_start)
                                begin
                                    state_reg <= S_SHRINK;
                                end
                                else
                                begin
                                    dropped_reg <= 1'b1;
                                end
                            end
                            FUNC_DEST:
                            begin
                                dest_reg  <= a_in;
                                endi_reg  <= count_inc;
                                state_reg <= S_INIT;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SHRINK:
                begin
                    if (shrink_done)
                    begin
                        count_reg <= count_inc;
                        state_reg <= S_IDLE;
                    end
                end
                S_INIT:
                begin
                    state_reg <= S_INIT2;
                end
                S_INIT2:
                begin
                    apex_reg  <= rd_l_reg;
                    left_reg  <= rd_l_reg;
                    right_reg <= rd_r_reg;
                    lidx_reg  <= '0;
                    ridx_reg  <= '0;
                    i_reg     <= CNT_W'(1);
                    n_reg     <= '0;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    state_reg <= ((i_reg <= endi_reg) && (n_reg <= endi_reg)) ? S_RD : S_DEST;
                end
                S_RD:
                begin
                    state_reg <= S_LD;
                end
                S_LD:
                begin
                    nl_reg      <= rd_l_reg;
                    nr_reg      <= rd_r_reg;
                    near_pl_reg <= near_eq(apex_reg, left_reg);
                    near_pr_reg <= near_eq(apex_reg, right_reg);
                    state_reg   <= S_M1;
                end
                S_M1, S_M2, S_M3, S_M4:
                begin
                    p1_reg    <= dcx * dby;
                    p2_reg    <= dbx * dcy;
                    state_reg <= state_t'(state_reg + 5'd1);
                end
                S_C1:
                begin
                    if (!tri_pos && near_pr_reg)
                    begin
                        right_reg <= nr_reg;
                        ridx_reg  <= i_reg;
                        state_reg <= S_M3;
                    end
                    else
                    begin
                        state_reg <= tri_pos ? S_M3 : S_M2;
                    end
                end
                S_C2:
                begin
                    if (tri_pos)
                    begin
                        right_reg <= nr_reg;
                        ridx_reg  <= i_reg;
                        state_reg <= S_M3;
                    end
                    else
                    begin
                        emit_reg  <= left_reg;
                        apex_reg  <= left_reg;
                        right_reg <= left_reg;
                        ridx_reg  <= lidx_reg;
                        i_reg     <= lidx_reg + CNT_W'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_C3:
                begin
                    if (!tri_neg && !near_pl_reg)
                    begin
                        state_reg <= S_M4;
                    end
                    else
                    begin
                        if (!tri_neg)
                        begin
                            left_reg <= nl_reg;
                            lidx_reg <= i_reg;
                        end
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_CHECK;
                    end
                end
                S_C4:
                begin
                    if (tri_neg)
                    begin
                        left_reg  <= nl_reg;
                        lidx_reg  <= i_reg;
                        i_reg     <= i_reg + CNT_W'(1);
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        emit_reg  <= right_reg;
                        apex_reg  <= right_reg;
                        left_reg  <= right_reg;
                        lidx_reg  <= ridx_reg;
                        i_reg     <= ridx_reg + CNT_W'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pt_reg    <= emit_reg;
                        out_last_reg  <= 1'b0;
                        out_ovf_reg   <= dropped_reg;
                        n_reg         <= n_reg + CNT_W'(1);
                        state_reg     <= S_CHECK;
                    end
                end
                S_DEST:
                begin
                    if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pt_reg    <= dest_reg;
                        out_last_reg  <= 1'b1;
                        out_ovf_reg   <= dropped_reg;
                        count_reg     <= '0;
                        dropped_reg   <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign wx         = out_pt_reg.x;
    assign wy         = out_pt_reg.y;
    assign wz         = out_pt_reg.z;
    assign last       = out_last_reg;
    assign overflowed = out_ovf_reg;

endmodule

[rtl/funnel_path_smoother_chk.sv]
// Port-level checker for the funnel path smoother, bound to the top level
`include "funnel_path_smoother_top_macros.svh"

module funnel_path_smoother_chk (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic [fps_pkg::FUNC_W-1:0]           func,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [fps_pkg::COORD_W-1:0]   wx,
    input logic                                 last
);
    import fps_pkg::*;

    `FPS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(wx), "stalled result changed")
    `FPS_ASSERT_NOW(a_corner_busy, out_valid && !last, in_stall, "corner waypoint pending while idle")
    `FPS_ASSERT_NEXT(a_run_busy, in_valid && !in_stall && func == FUNC_DEST, in_stall, "run did not start")
    `FPS_ASSERT_NEXT(a_start_quick, in_valid && !in_stall && (func == FUNC_START || func == FUNC_NONE), !in_stall, "start transfer left block busy")

endmodule

bind funnel_path_smoother_top funnel_path_smoother_chk u_fps_chk (.*);
